// ===== rtl/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg: shared definitions for the Hermite spline evaluator
// Widths, op codes, controller/datapath command and status types, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  localparam int CW        = 32;               // coordinate width, signed Q15.16
  localparam int TENS_W    = 24;               // tension, unsigned Q8.16
  localparam int TENS_FRAC = 16;
  localparam int U_W       = 17;               // curve parameter, unsigned Q1.16
  localparam int U_FRAC    = 16;

  localparam int MW   = CW + 1;                // start-to-end difference / its magnitude
  localparam int SQW  = 2 * MW;                // sum of three squares
  localparam int NW   = CW;                    // tangent norm
  localparam int PW   = CW + TENS_W;           // |t| * tension
  localparam int PLO  = PW / 2;                // split point of PW for the second product
  localparam int NUMW = PW + MW;               // |t| * tension * L
  localparam int DVW  = NUMW - TENS_FRAC;      // dividend after dropping tension fraction
  localparam int QW   = TENS_W + MW - TENS_FRAC + 1; // scaled tangent magnitude
  localparam int SW   = QW + 1;                // signed scaled tangent
  localparam int CFW  = SW + 3;                // coefficient / sum working width
  localparam int EW   = CW + 3;                // evaluation accumulator

  localparam logic [U_W-1:0] U_ONE = U_W'(1) << U_FRAC;

  localparam logic [1:0] OP_LOAD_START = 2'd0;
  localparam logic [1:0] OP_LOAD_END   = 2'd1;
  localparam logic [1:0] OP_EVAL       = 2'd2;

  localparam logic [1:0] VEC_D  = 2'd0;        // end - start
  localparam logic [1:0] VEC_T0 = 2'd1;        // start tangent
  localparam logic [1:0] VEC_T1 = 2'd2;        // end tangent

  localparam logic signed [CFW-1:0] CMAX = CFW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [CFW-1:0] CMIN = ~CMAX;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_SQ,
    DP_SQRT_GO,
    DP_SQRT_WAIT,
    DP_TMUL,
    DP_NMUL_HI,
    DP_NMUL_LO,
    DP_DIV_GO,
    DP_DIV_WAIT,
    DP_COEF,
    DP_EV1,
    DP_EV2,
    DP_EV3,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] vsel;
    logic [1:0] axis;
    logic       esel;
    logic       in_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic stale;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic sat_hit(input logic signed [CFW-1:0] v);
    return (v > CMAX) || (v < CMIN);
  endfunction

  function automatic logic signed [CW-1:0] sat_val(input logic signed [CFW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > CMAX) begin
      r = CMAX[CW-1:0];
    end else if (v < CMIN) begin
      r = CMIN[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hse_in_if.sv =====
// ----------------------------------------------------------------------------
// hse_in_if: input word channel
// Valid/ready channel carrying one load or evaluate word.
// ----------------------------------------------------------------------------
`default_nettype none

interface hse_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic signed [hse_pkg::CW-1:0]      pos_x;
  logic signed [hse_pkg::CW-1:0]      pos_y;
  logic signed [hse_pkg::CW-1:0]      pos_z;
  logic signed [hse_pkg::CW-1:0]      tan_x;
  logic signed [hse_pkg::CW-1:0]      tan_y;
  logic signed [hse_pkg::CW-1:0]      tan_z;
  logic [hse_pkg::TENS_W-1:0]         tension;
  logic [hse_pkg::U_W-1:0]            u_param;
  logic                               last_sample;

  modport source (output valid, op, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
                  tension, u_param, last_sample, input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, tan_x, tan_y, tan_z,
                  tension, u_param, last_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/hse_out_if.sv =====
// ----------------------------------------------------------------------------
// hse_out_if: result word channel
// Valid/ready channel carrying one curve point.
// ----------------------------------------------------------------------------
`default_nettype none

interface hse_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [hse_pkg::CW-1:0] out_x;
  logic signed [hse_pkg::CW-1:0] out_y;
  logic signed [hse_pkg::CW-1:0] out_z;
  logic                          is_last;
  logic                          clipped;

  modport source (output valid, out_x, out_y, out_z, is_last, clipped, input ready);
  modport sink   (input valid, out_x, out_y, out_z, is_last, clipped, output ready);
endinterface

`default_nettype wire

// ===== rtl/hse_sqrt.sv =====
// ----------------------------------------------------------------------------
// hse_sqrt: iterative integer square root
// Restoring method, one result bit per cycle; floor(sqrt(radicand)).
// ----------------------------------------------------------------------------
`default_nettype none

module hse_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [hse_pkg::SQW-1:0]   radicand,
  output logic                           done,
  output logic [hse_pkg::MW-1:0]         root
);
  import hse_pkg::*;

  localparam int SQ_IT = SQW / 2;
  localparam int CNTW  = $clog2(SQ_IT + 1);
  localparam int REMW  = MW + 2;

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [SQW-1:0]  rad;
  logic [REMW-1:0] rem;
  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;

  // root top bit is still clear on every step that forms a trial
  always_comb begin
    rem_sh = {rem[REMW-3:0], rad[SQW-1 -: 2]};
    trial  = {1'b0, root[MW-2:0], 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= rad << 2;
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[MW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNTW'(SQ_IT - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hse_div.sv =====
// ----------------------------------------------------------------------------
// hse_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; high quotient bits known zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_div (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [hse_pkg::DVW-1:0]  dividend,
  input  wire logic [hse_pkg::NW-1:0]   divisor,
  output logic                          done,
  output logic [hse_pkg::QW-1:0]        quotient
);
  import hse_pkg::*;

  localparam int CNTW = $clog2(DVW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DVW-1:0]  dvd;
  logic [NW-1:0]   den;
  logic [NW-1:0]   rem;
  logic [NW:0]     sh;
  logic [NW:0]     dif;
  logic            ge;

  always_comb begin
    sh  = {rem, dvd[DVW-1]};
    dif = sh - {1'b0, den};
    ge  = sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        dvd      <= dividend;
        den      <= divisor;
        rem      <= '0;
        quotient <= '0;
      end else if (busy) begin
        dvd      <= dvd << 1;
        rem      <= ge ? dif[NW-1:0] : sh[NW-1:0];
        quotient <= {quotient[QW-2:0], ge};
        cnt      <= cnt + 1'b1;
        if (cnt == CNTW'(DVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hse_dp.sv =====
// ----------------------------------------------------------------------------
// hse_dp: segment datapath
// Endpoint storage, shared rebuild multiplier, root and divide units,
// coefficients, per-axis evaluation and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hse_pkg::dp_cmd_t  cmd,
  output hse_pkg::dp_stat_t      stat,
  hse_in_if.sink                 items,
  hse_out_if.source              points
);
  import hse_pkg::*;

  logic signed [CW-1:0] sp [3];
  logic signed [CW-1:0] st [3];
  logic signed [CW-1:0] ep [3];
  logic signed [CW-1:0] et [3];
  logic [TENS_W-1:0]    ss;
  logic [TENS_W-1:0]    es;
  logic [MW-1:0]        len;
  logic [NW-1:0]        n0;
  logic [NW-1:0]        n1;
  logic [NUMW-1:0]      acc;
  logic [PW-1:0]        p;
  logic signed [SW-1:0] s0 [3];
  logic signed [SW-1:0] s1 [3];
  logic signed [CW-1:0] coef [4][3];
  logic                 coef_clip;
  logic                 stale;
  logic [U_W-1:0]       u;
  logic [U_W-1:0]       u2;
  logic [U_W-1:0]       u3;
  logic                 last;
  logic signed [EW-1:0] ev [3];
  logic                 ovalid;

  logic                 accept;
  logic signed [MW-1:0] diff [3];
  logic [MW-1:0]        vm;
  logic signed [CW-1:0] tsel;
  logic [MW-1:0]        tmag;
  logic [MW-1:0]        ma;
  logic [MW-1:0]        mb;
  logic [SQW-1:0]       prod;
  logic [2*U_W-1:0]     uprod;
  logic [U_W-1:0]       uk;
  logic [1:0]           kidx;
  logic signed [CW+U_W:0]  tprod [3];
  logic signed [CW+U_W:0]  tsh [3];
  logic signed [CFW-1:0] c2w [3];
  logic signed [CFW-1:0] c3w [3];
  logic signed [CFW-1:0] c1w [3];
  logic signed [CFW-1:0] evw [3];
  logic                 cclip;
  logic                 oclip;
  logic [NW-1:0]        nsel;
  logic [QW-1:0]        quot;
  logic [MW-1:0]        root;
  logic                 sq_done;
  logic                 dv_done;
  logic signed [SW-1:0] qs;
  logic                 out_free;

  function automatic logic [MW-1:0] smag(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  assign accept   = items.valid & cmd.in_ready;
  assign out_free = ~ovalid | points.ready;
  assign items.ready = cmd.in_ready;

  assign stat.stale     = stale;
  assign stat.sqrt_done = sq_done;
  assign stat.div_done  = dv_done;
  assign stat.out_free  = out_free;

  // shared rebuild multiplier operand select
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {ep[a][CW-1], ep[a]} - {sp[a][CW-1], sp[a]};
    end
    case (cmd.vsel)
      VEC_D:   vm = smag(diff[cmd.axis]);
      VEC_T0:  vm = smag({st[cmd.axis][CW-1], st[cmd.axis]});
      VEC_T1:  vm = smag({et[cmd.axis][CW-1], et[cmd.axis]});
      default: vm = '0;
    endcase
    tsel = cmd.esel ? et[cmd.axis] : st[cmd.axis];
    tmag = smag({tsel[CW-1], tsel});
    case (cmd.op)
      DP_SQ: begin
        ma = vm;
        mb = vm;
      end
      DP_TMUL: begin
        ma = tmag;
        mb = MW'(cmd.esel ? es : ss);
      end
      DP_NMUL_HI: begin
        ma = MW'(p[PW-1:PLO]);
        mb = len;
      end
      DP_NMUL_LO: begin
        ma = MW'(p[PLO-1:0]);
        mb = len;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = ma * mb;
    nsel = cmd.esel ? n1 : n0;
    qs   = {1'b0, quot};
  end

  // coefficients and evaluation terms, one lane per axis
  always_comb begin
    case (cmd.op)
      DP_EV2: begin
        uk   = u2;
        kidx = 2'd2;
      end
      DP_EV3: begin
        uk   = u3;
        kidx = 2'd3;
      end
      default: begin
        uk   = u;
        kidx = 2'd1;
      end
    endcase
    uprod = (cmd.op == DP_EV1) ? u * u : u2 * u;
    cclip = 1'b0;
    oclip = 1'b0;
    for (int a = 0; a < 3; a++) begin
      c1w[a] = CFW'(s0[a]);
      c2w[a] = 3 * CFW'(diff[a]) - 2 * CFW'(s0[a]) - CFW'(s1[a]);
      c3w[a] = CFW'(s0[a]) + CFW'(s1[a]) - 2 * CFW'(diff[a]);
      cclip  = cclip | sat_hit(c1w[a]) | sat_hit(c2w[a]) | sat_hit(c3w[a]);
      tprod[a] = coef[kidx][a] * $signed({1'b0, uk});
      tsh[a]   = tprod[a] >>> U_FRAC;
      evw[a]   = CFW'(ev[a]);
      oclip    = oclip | sat_hit(evw[a]);
    end
  end

  hse_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == DP_SQRT_GO),
    .radicand (acc[SQW-1:0]),
    .done     (sq_done),
    .root     (root)
  );

  hse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == DP_DIV_GO),
    .dividend (acc[NUMW-1:TENS_FRAC]),
    .divisor  (nsel),
    .done     (dv_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        sp[a] <= '0;
        st[a] <= '0;
        ep[a] <= '0;
        et[a] <= '0;
      end
      ss        <= '0;
      es        <= '0;
      stale     <= 1'b1;
      coef_clip <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      // result register: load on the output step, drop once taken
      if (cmd.op == DP_OUT && out_free) begin
        ovalid <= 1'b1;
      end else if (points.ready) begin
        ovalid <= 1'b0;
      end
      if (accept) begin
        if (items.op == OP_LOAD_START) begin
          sp[0] <= items.pos_x; sp[1] <= items.pos_y; sp[2] <= items.pos_z;
          st[0] <= items.tan_x; st[1] <= items.tan_y; st[2] <= items.tan_z;
          ss    <= items.tension;
          stale <= 1'b1;
        end else if (items.op == OP_LOAD_END) begin
          ep[0] <= items.pos_x; ep[1] <= items.pos_y; ep[2] <= items.pos_z;
          et[0] <= items.tan_x; et[1] <= items.tan_y; et[2] <= items.tan_z;
          es    <= items.tension;
          stale <= 1'b1;
        end else if (items.op == OP_EVAL) begin
          u    <= (items.u_param > U_ONE) ? U_ONE : items.u_param;
          last <= items.last_sample;
        end
      end
      case (cmd.op)
        DP_SQ: begin
          acc <= (cmd.axis == 2'd0) ? NUMW'(prod) : acc + NUMW'(prod);
        end
        DP_SQRT_WAIT: begin
          if (sq_done) begin
            case (cmd.vsel)
              VEC_D:   len <= root;
              VEC_T0:  n0  <= root[NW-1:0];
              default: n1  <= root[NW-1:0];
            endcase
          end
        end
        DP_TMUL: begin
          p <= prod[PW-1:0];
        end
        DP_NMUL_HI: begin
          acc <= NUMW'(prod) << PLO;
        end
        DP_NMUL_LO: begin
          acc <= acc + NUMW'(prod);
        end
        DP_DIV_WAIT: begin
          if (dv_done) begin
            if (cmd.esel) begin
              s1[cmd.axis] <= (nsel == '0) ? '0 : (tsel[CW-1] ? -qs : qs);
            end else begin
              s0[cmd.axis] <= (nsel == '0) ? '0 : (tsel[CW-1] ? -qs : qs);
            end
          end
        end
        DP_COEF: begin
          for (int a = 0; a < 3; a++) begin
            coef[0][a] <= sp[a];
            coef[1][a] <= sat_val(c1w[a]);
            coef[2][a] <= sat_val(c2w[a]);
            coef[3][a] <= sat_val(c3w[a]);
          end
          coef_clip <= cclip;
          stale     <= 1'b0;
        end
        DP_EV1: begin
          u2 <= uprod[U_FRAC +: U_W];
          for (int a = 0; a < 3; a++) begin
            ev[a] <= EW'(coef[0][a]) + tsh[a][EW-1:0];
          end
        end
        DP_EV2: begin
          u3 <= uprod[U_FRAC +: U_W];
          for (int a = 0; a < 3; a++) begin
            ev[a] <= ev[a] + tsh[a][EW-1:0];
          end
        end
        DP_EV3: begin
          for (int a = 0; a < 3; a++) begin
            ev[a] <= ev[a] + tsh[a][EW-1:0];
          end
        end
        DP_OUT: begin
          if (out_free) begin
            points.out_x   <= sat_val(evw[0]);
            points.out_y   <= sat_val(evw[1]);
            points.out_z   <= sat_val(evw[2]);
            points.is_last <= last;
            points.clipped <= coef_clip | oclip;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign points.valid = ovalid;

endmodule

`default_nettype wire

// ===== rtl/hse_ctrl.sv =====
// ----------------------------------------------------------------------------
// hse_ctrl: sequencing state machine
// Accepts words, steps the rebuild and evaluation sequences in the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_op,
  input  wire hse_pkg::dp_stat_t stat,
  output hse_pkg::dp_cmd_t       cmd
);
  import hse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_TMUL,
    S_NHI,
    S_NLO,
    S_DIV_GO,
    S_DIV_WAIT,
    S_COEF,
    S_EV1,
    S_EV2,
    S_EV3,
    S_OUT
  } state_t;

  state_t     state;
  logic [1:0] vsel;
  logic [1:0] axis;
  logic       esel;

  always_comb begin
    cmd.vsel     = vsel;
    cmd.axis     = axis;
    cmd.esel     = esel;
    cmd.in_ready = (state == S_IDLE);
    case (state)
      S_SQ:        cmd.op = DP_SQ;
      S_SQRT_GO:   cmd.op = DP_SQRT_GO;
      S_SQRT_WAIT: cmd.op = DP_SQRT_WAIT;
      S_TMUL:      cmd.op = DP_TMUL;
      S_NHI:       cmd.op = DP_NMUL_HI;
      S_NLO:       cmd.op = DP_NMUL_LO;
      S_DIV_GO:    cmd.op = DP_DIV_GO;
      S_DIV_WAIT:  cmd.op = DP_DIV_WAIT;
      S_COEF:      cmd.op = DP_COEF;
      S_EV1:       cmd.op = DP_EV1;
      S_EV2:       cmd.op = DP_EV2;
      S_EV3:       cmd.op = DP_EV3;
      S_OUT:       cmd.op = DP_OUT;
      default:     cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vsel  <= VEC_D;
      axis  <= '0;
      esel  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_op == OP_EVAL) begin
            vsel  <= VEC_D;
            axis  <= '0;
            esel  <= 1'b0;
            state <= stat.stale ? S_SQ : S_EV1;
          end
        end
        S_SQ: begin
          if (axis == 2'd2) begin
            state <= S_SQRT_GO;
          end else begin
            axis <= axis + 1'b1;
          end
        end
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (stat.sqrt_done) begin
            axis <= '0;
            if (vsel == VEC_T1) begin
              esel  <= 1'b0;
              state <= S_TMUL;
            end else begin
              vsel  <= vsel + 1'b1;
              state <= S_SQ;
            end
          end
        end
        S_TMUL:   state <= S_NHI;
        S_NHI:    state <= S_NLO;
        S_NLO:    state <= S_DIV_GO;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (stat.div_done) begin
            if (axis != 2'd2) begin
              axis  <= axis + 1'b1;
              state <= S_TMUL;
            end else if (!esel) begin
              esel  <= 1'b1;
              axis  <= '0;
              state <= S_TMUL;
            end else begin
              state <= S_COEF;
            end
          end
        end
        S_COEF: state <= S_EV1;
        S_EV1:  state <= S_EV2;
        S_EV2:  state <= S_EV3;
        S_EV3:  state <= S_OUT;
        S_OUT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hermite_spline_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// hermite_spline_evaluator_unit: 3D cubic Hermite segment evaluator
// Loads segment endpoints and returns saturated Q15.16 points on the curve.
// ----------------------------------------------------------------------------
// Usage:
//   items  : input words. op 0 loads the start point, op 1 the end point
//            (position, tangent, tension); op 2 evaluates at u_param.
//   points : one result word per evaluate word (x, y, z, is_last, clipped).
//   Loads produce nothing. When the coefficients are current, an evaluate
//   word runs the three term steps and the output step before its result
//   is valid; the next word is taken on the cycle after the result is
//   registered. After any load the first evaluate rebuilds the coefficients:
//   three sums of squares plus 33-step roots, then six 73-step divisions
//   for the scaled tangents. The bit-serial root and divide units set the
//   rebuild time. One word is in flight at a time.
//   Reset clears both endpoints and marks the coefficients stale, so an
//   evaluate before any load returns the origin.
//   The result sits in an output register; a new word is accepted while it
//   waits, but a finished point holds in the sequencer until points.ready
//   frees the register.
// ----------------------------------------------------------------------------
`default_nettype none

module hermite_spline_evaluator_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  hse_in_if.sink     items,
  hse_out_if.source  points
);
  import hse_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decides each cycle's datapath step
  hse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_op    (items.op),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: storage, arithmetic and the result register
  hse_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .items  (items),
    .points (points)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: Hermite spline evaluator testbench
// Table-driven directed words, then random load/evaluate traffic, checked
// against an in-bench fixed-point model of the segment and its cubic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hse_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hse_in_if  items ();
  hse_out_if points ();

  hermite_spline_evaluator_unit uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items.sink),
    .points (points.source)
  );

  // One input word as the bench sees it.
  typedef struct {
    logic [1:0]               op;
    logic signed [CW-1:0]     p [3];
    logic signed [CW-1:0]     t [3];
    logic [TENS_W-1:0]        tens;
    logic [U_W-1:0]           u;
    logic                     lst;
  } item_t;

  // One expected curve point.
  typedef struct {
    logic signed [CW-1:0] x, y, z;
    logic                 lst, clip;
  } point_t;

  point_t point_q[$];
  int     errors = 0;

  // Segment state mirrored from the block.
  logic signed [63:0] seg_pos [2][3];
  logic signed [63:0] seg_dir [2][3];
  logic [63:0]        seg_tens [2];
  logic signed [63:0] coef [12];
  bit                 stale;
  bit                 coef_clip;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] root128(input logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] vec_len(input logic signed [63:0] a, b, c);
    logic [127:0] s;
    s = {64'd0, mag64(a)} * {64'd0, mag64(a)} + {64'd0, mag64(b)} * {64'd0, mag64(b)}
      + {64'd0, mag64(c)} * {64'd0, mag64(c)};
    return root128(s);
  endfunction

  function automatic logic signed [63:0] clamp_coord(input logic signed [63:0] v,
                                                     inout bit hit);
    if (v > 64'sh7FFFFFFF) begin
      hit = 1; return 64'sh7FFFFFFF;
    end
    if (v < -64'sh80000000) begin
      hit = 1; return -64'sh80000000;
    end
    return v;
  endfunction

  // Tangent component scaled to tension * chord length over tangent norm.
  function automatic logic signed [63:0] scale_tan(input logic signed [63:0] t,
      input logic [63:0] nrm, input logic [63:0] tens, input logic [63:0] len);
    logic [191:0] num;
    logic [191:0] q;
    if (nrm == 0) return 0;
    num = {128'd0, mag64(t)} * {128'd0, tens} * {128'd0, len};
    q = num / ({128'd0, nrm} << TENS_FRAC);
    return t < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  task automatic rebuild_coefs();
    logic signed [63:0] d [3];
    logic signed [63:0] s0, s1;
    logic [63:0]        len, n0, n1;
    bit                 hit;
    hit = 0;
    for (int a = 0; a < 3; a++) d[a] = seg_pos[1][a] - seg_pos[0][a];
    len = vec_len(d[0], d[1], d[2]);
    n0  = vec_len(seg_dir[0][0], seg_dir[0][1], seg_dir[0][2]);
    n1  = vec_len(seg_dir[1][0], seg_dir[1][1], seg_dir[1][2]);
    for (int a = 0; a < 3; a++) begin
      s0 = scale_tan(seg_dir[0][a], n0, seg_tens[0], len);
      s1 = scale_tan(seg_dir[1][a], n1, seg_tens[1], len);
      coef[a]     = seg_pos[0][a];
      coef[3 + a] = clamp_coord(s0, hit);
      coef[6 + a] = clamp_coord(3 * d[a] - 2 * s0 - s1, hit);
      coef[9 + a] = clamp_coord(-2 * d[a] + s0 + s1, hit);
    end
    coef_clip = hit;
    stale = 0;
  endtask

  // c * u / 2^16, floor
  function automatic logic signed [63:0] cubic_term(input logic signed [63:0] c,
                                                    input logic [63:0] u);
    return (c * $signed(u)) >>> U_FRAC;
  endfunction

  task automatic segment_reset();
    for (int e = 0; e < 2; e++) begin
      for (int a = 0; a < 3; a++) begin
        seg_pos[e][a] = 0; seg_dir[e][a] = 0;
      end
      seg_tens[e] = 0;
    end
    for (int i = 0; i < 12; i++) coef[i] = 0;
    stale = 1; coef_clip = 0;
  endtask

  // Apply one word to the mirrored segment; push a point for evaluates.
  task automatic predict_word(input item_t w);
    logic [63:0]        u, u2, u3;
    logic signed [63:0] v [3];
    bit                 hit;
    point_t             pt;
    if (w.op == OP_LOAD_START || w.op == OP_LOAD_END) begin
      for (int a = 0; a < 3; a++) begin
        seg_pos[w.op][a] = w.p[a];
        seg_dir[w.op][a] = w.t[a];
      end
      seg_tens[w.op] = w.tens;
      stale = 1;
    end else if (w.op == OP_EVAL) begin
      u  = (w.u > U_ONE) ? U_ONE : w.u;
      u2 = (u * u) >> U_FRAC;
      u3 = (u2 * u) >> U_FRAC;
      if (stale) rebuild_coefs();
      hit = coef_clip;
      for (int a = 0; a < 3; a++)
        v[a] = clamp_coord(coef[a] + cubic_term(coef[3 + a], u)
                           + cubic_term(coef[6 + a], u2) + cubic_term(coef[9 + a], u3), hit);
      pt.x = v[0][CW-1:0]; pt.y = v[1][CW-1:0]; pt.z = v[2][CW-1:0];
      pt.lst = w.lst; pt.clip = hit;
      point_q.push_back(pt);
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table. Typed expectations only where the answer is obvious;
  // has_exp = 0 rows go through the model like the random part does.
  // --------------------------------------------------------------------------
  typedef struct {
    item_t  w;
    bit     has_exp;
    point_t exp_pt;
  } row_t;

  row_t rows[$];

  function automatic item_t mk(input logic [1:0] op, input logic signed [CW-1:0] px, py, pz,
      tx, ty, tz, input logic [TENS_W-1:0] tens, input logic [U_W-1:0] u, input logic lst);
    item_t w;
    w.op = op; w.p[0] = px; w.p[1] = py; w.p[2] = pz;
    w.t[0] = tx; w.t[1] = ty; w.t[2] = tz; w.tens = tens; w.u = u; w.lst = lst;
    return w;
  endfunction

  function automatic item_t rand_word(input logic [1:0] op, input bit wild);
    item_t w;
    int    sh;
    for (int a = 0; a < 3; a++) begin
      sh = wild ? 0 : $urandom_range(31, 4);
      w.p[a] = $signed($urandom()) >>> sh;
      w.t[a] = $signed($urandom()) >>> $urandom_range(31, 0);
    end
    w.op   = op;
    w.tens = wild ? TENS_W'($urandom()) : TENS_W'($urandom_range(24'h020000, 0));
    w.u    = ($urandom_range(9, 0) == 0) ? U_W'($urandom()) : U_W'($urandom_range(U_ONE, 0));
    w.lst  = 1'($urandom());
    return w;
  endfunction

  task automatic add_row(input item_t w, input bit he, input point_t e);
    row_t r;
    r.w = w; r.has_exp = he; r.exp_pt = e;
    rows.push_back(r);
  endtask

  localparam logic signed [CW-1:0] PMAX = 32'sh7FFFFFFF;
  localparam logic signed [CW-1:0] PMIN = 32'sh80000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  task automatic build_table();
    point_t z, pmx, none;
    z = '{0, 0, 0, 1'b0, 1'b0};
    none = z;
    // evaluate straight after reset returns the origin
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 17'h1FFFF, 1'b0), 1, z);
    z.lst = 1'b1;
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, U_ONE, 1'b1), 1, z);
    // unused op is dropped
    add_row(mk(OP_UNUSED, -1, -1, -1, -1, -1, -1, '1, '1, 1'b1), 0, none);
    // coincident endpoints at the max corner, zero tangents: constant point
    add_row(mk(OP_LOAD_START, PMAX, PMAX, PMAX, 0, 0, 0, '1, 0, 0), 0, none);
    add_row(mk(OP_LOAD_END, PMAX, PMAX, PMAX, 0, 0, 0, '1, 0, 0), 0, none);
    pmx = '{PMAX, PMAX, PMAX, 1'b0, 1'b0};
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, pmx);
    pmx.lst = 1'b1;
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, U_ONE, 1), 1, pmx);
    // full-span segment with extreme tangents and tension
    add_row(mk(OP_LOAD_START, PMIN, PMIN, PMIN, PMAX, PMIN, 1, '1, 0, 0), 0, none);
    add_row(mk(OP_LOAD_END, PMAX, PMAX, PMAX, PMIN, PMAX, -1, '1, 0, 0), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 17'h08000, 0), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, U_ONE, 1), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 17'h1FFFF, 1), 0, none);
    // ordinary segment, one zero tangent, then tension changes
    add_row(mk(OP_LOAD_START, 32'sh10000, -32'sh20000, 0, 0, 0, 0, 24'h010000, 0, 0), 0, none);
    add_row(mk(OP_LOAD_END, 32'sh50000, 32'sh30000, 32'sh8000, 32'sh10000, 0, 0, 24'h008000,
               0, 0), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 17'h04000, 0), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 17'h0C000, 1), 0, none);
    add_row(mk(OP_LOAD_START, 32'sh10000, -32'sh20000, 0, -5, 7, 3, '1, 0, 0), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 17'h0AAAA, 0), 0, none);
    add_row(mk(OP_LOAD_END, 32'sh10000, -32'sh20000, 0, 9, 9, 9, '1, 0, 0), 0, none);
    add_row(mk(OP_EVAL, 0, 0, 0, 0, 0, 0, 0, 17'h00001, 1), 0, none);
  endtask

  // --------------------------------------------------------------------------
  // Sender: table rows, then random segments with sampling runs.
  // --------------------------------------------------------------------------
  point_t typed_q[$];    // typed expectations, aligned with point_q by order
  bit     typed_flag_q[$];
  bit     idle_on = 1;
  bit     stim_done = 0;
  bit     hold_out = 0;

  task automatic drive_word(input item_t w);
    items.op <= w.op;
    items.pos_x <= w.p[0]; items.pos_y <= w.p[1]; items.pos_z <= w.p[2];
    items.tan_x <= w.t[0]; items.tan_y <= w.t[1]; items.tan_z <= w.t[2];
    items.tension <= w.tens; items.u_param <= w.u; items.last_sample <= w.lst;
  endtask

  // Offer one word, with an optional idle burst first; returns once accepted.
  task automatic send_word(input item_t w);
    if (idle_on && $urandom_range(3, 0) == 0) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk);
    end
    drive_word(w);
    items.valid <= 1'b1;
    do @(posedge clk); while (!items.ready);
    predict_word(w);
  endtask

  initial begin
    item_t w;
    int    n, runs;
    items.valid <= 1'b0;
    drive_word(mk(OP_LOAD_START, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    segment_reset();
    build_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].w.op == OP_EVAL) begin
        typed_flag_q.push_back(rows[i].has_exp);
        typed_q.push_back(rows[i].exp_pt);
      end
    end

    // Pause until everything is drained.
    items.valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);

    n = 0;
    runs = 0;
    while (n < 550) begin
      // long receiver hold while the sender keeps offering
      if (runs == 3) hold_out = 1;
      if (runs == 60) idle_on = 0;    // last stretch runs flat out
      if ($urandom_range(9, 0) == 0) begin
        w = rand_word(2'($urandom_range(3, 0)), 1);   // noise, lone loads and lone evaluates
        send_word(w);
        n++;
      end else begin
        if ($urandom_range(3, 0) != 0) begin
          send_word(rand_word(OP_LOAD_START, $urandom_range(7, 0) == 0)); n++;
        end
        if ($urandom_range(3, 0) != 0) begin
          send_word(rand_word(OP_LOAD_END, $urandom_range(7, 0) == 0)); n++;
        end
        repeat ($urandom_range(8, 1)) begin
          w = rand_word(OP_EVAL, 0);
          w.lst = 1'b0;
          send_word(w); n++;
        end
        w = rand_word(OP_EVAL, 0);
        w.lst = 1'b1;
        send_word(w); n++;
      end
      runs++;
    end
    items.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stalls, one long hold counted in its own loop.
  initial begin
    points.ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_out) begin
        points.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_out = 0;
      end
      if (idle_on && $urandom_range(7, 0) == 0) begin
        points.ready <= 1'b0;
        repeat ($urandom_range(19, 1)) @(posedge clk);
      end
      points.ready <= 1'b1;
    end
  end

  // Checker: compare each accepted point with the oldest expectation.
  always @(posedge clk) begin
    point_t e;
    bit     bad;
    if (!rst && points.valid && points.ready) begin
      if (point_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected point x=%h y=%h z=%h", points.out_x,
                                   points.out_y, points.out_z);
      end else begin
        e = point_q.pop_front();
        // typed rows must agree with the model too
        if (typed_flag_q.size() != 0) begin
          if (typed_flag_q[0] && ((typed_q[0].x !== e.x) || (typed_q[0].y !== e.y)
              || (typed_q[0].z !== e.z) || (typed_q[0].lst !== e.lst)
              || (typed_q[0].clip !== e.clip))) begin
            errors++;
            if (errors <= 10) $display("table row disagrees with model");
          end
          void'(typed_flag_q.pop_front());
          void'(typed_q.pop_front());
        end
        bad = (points.out_x !== e.x) || (points.out_y !== e.y) || (points.out_z !== e.z)
           || (points.is_last !== e.lst) || (points.clipped !== e.clip);
        if (bad) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp %h %h %h l%b c%b got %h %h %h l%b c%b",
                     e.x, e.y, e.z, e.lst, e.clip, points.out_x, points.out_y,
                     points.out_z, points.is_last, points.clipped);
        end
      end
    end
  end

  // End of run: drain, wait for stray words, then report.
  initial begin
    wait (stim_done);
    while (point_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && point_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: a rebuild for every word plus full stalls fits well inside.
  initial begin
    #60ms;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
